>>> hw/rtl/echr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echr_pkg
// Shared codes and types for the Ethernet controller host register block.
// ----------------------------------------------------------------------------
package echr_pkg;

   localparam int unsigned RAM_ADDR_W = 16;
   localparam int unsigned RAM_DATA_W = 8;

   // Transaction kinds
   localparam logic KIND_READ  = 1'b0;
   localparam logic KIND_WRITE = 1'b1;

   // Register indexes
   localparam logic [2:0] REG_CMD    = 3'd0;
   localparam logic [2:0] REG_CFG1   = 3'd1;
   localparam logic [2:0] REG_CFG2   = 3'd2;
   localparam logic [2:0] REG_RX_END = 3'd3;
   localparam logic [2:0] REG_WINDOW = 3'd4;
   localparam logic [2:0] REG_RX_PTR = 3'd5;
   localparam logic [2:0] REG_TX_PTR = 3'd6;
   localparam logic [2:0] REG_DMA    = 3'd7;

   // Buffer window codes (config one, low nibble)
   localparam logic [3:0] WIN_STATION_LAST = 4'd5;
   localparam logic [3:0] WIN_TX_END       = 4'd7;
   localparam logic [3:0] WIN_RAM          = 4'd8;

   localparam logic [15:0] END_OFFSET = 16'h0100;
   localparam logic [15:0] NO_DATA    = 16'h00ff;

   typedef struct packed {
      logic                  wr_en;
      logic [RAM_ADDR_W-1:0] wr_addr;
      logic [RAM_DATA_W-1:0] wr_data;
      logic                  rd_en;
      logic [RAM_ADDR_W-1:0] rd_addr0;
      logic [RAM_ADDR_W-1:0] rd_addr1;
   } ram_req_type;

endpackage

>>> hw/rtl/echr_buffer_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echr_buffer_ram
// 64 KiB packet buffer: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module echr_buffer_ram (
   input  logic                  clock,
   input  echr_pkg::ram_req_type ram_req,
   output logic [7:0]            rd_data0,
   output logic [7:0]            rd_data1
);
   import echr_pkg::*;

   logic [RAM_DATA_W-1:0] mem [0:(1 << RAM_ADDR_W)-1];
   logic [RAM_DATA_W-1:0] rd_data0_ff;
   logic [RAM_DATA_W-1:0] rd_data1_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data0_ff <= mem[ram_req.rd_addr0];
         rd_data1_ff <= mem[ram_req.rd_addr1];
      end
   end

   assign rd_data0 = rd_data0_ff;
   assign rd_data1 = rd_data1_ff;

endmodule

>>> hw/rtl/ethernet_controller_host_registers_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Results are registered; a buffer RAM read passes through the registered RAM
// read port first. One transaction per cycle while the result register can load;
// a buffer RAM access holds off the next one (second byte write, or delivery of
// the read word from the RAM port). Reset: synchronous; control and register
// state clear, result and RAM write holding registers do not, RAM undefined.
// ----------------------------------------------------------------------------
// ethernet_controller_host_registers_unit
// Host register file of an Ethernet controller with buffer window to RAM.
// ----------------------------------------------------------------------------
module ethernet_controller_host_registers_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [2:0]  req_reg_index,
   input  logic [15:0] req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_read_data,
   output logic        rsp_irq
);
   import echr_pkg::*;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_RD   = 2'd1;
   localparam logic [1:0] PH_WR   = 2'd2;

   function automatic logic [15:0] adv_read(input logic [15:0] addr,
                                            input logic [15:0] tx_end);
      logic [15:0] n;
      n = addr + 16'd1;
      if (n == 16'd0) n = tx_end + END_OFFSET;
      return n;
   endfunction

   function automatic logic [15:0] adv_write(input logic [15:0] addr,
                                             input logic [15:0] tx_end);
      logic [15:0] n;
      n = addr + 16'd1;
      if (n == tx_end + END_OFFSET) n = 16'd0;
      return n;
   endfunction

   function automatic logic [15:0] cmd_status(input logic [15:0] st,
                                              input logic [15:0] c);
      logic [15:0] s;
      s = {st[15:4], c[3:0]};
      s[7:4] = s[7:4] & ~c[7:4];
      for (int u = 0; u < 3; u++) begin
         if (c[8+u] && c[11+u]) s[4+u] = 1'b1;
         else if (c[8+u]) s[8+u] = 1'b1;
         else if (c[11+u]) s[8+u] = 1'b0;
      end
      if (c[14]) begin
         s[15] = 1'b1;
         s[13] = 1'b1;
         s[14] = 1'b0;
      end
      if (c[15]) begin
         s[15] = 1'b0;
         s[13] = 1'b0;
         s[14] = 1'b1;
      end
      return s;
   endfunction

   logic [15:0] command_ff, command_in;
   logic [15:0] status_ff, status_in;
   logic [15:0] cfg1_ff, cfg1_in;
   logic [15:0] cfg2_ff, cfg2_in;
   logic [15:0] rx_end_ff, rx_end_in;
   logic [15:0] tx_end_ff, tx_end_in;
   logic [15:0] rx_ptr_ff, rx_ptr_in;
   logic [15:0] tx_ptr_ff, tx_ptr_in;
   logic [15:0] dma_ff, dma_in;
   logic [1:0]  phase_ff, phase_in;
   logic [15:0] wr_addr_ff, wr_addr_in;
   logic [7:0]  wr_byte_ff, wr_byte_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [15:0] rsp_data_ff, rsp_data_in;
   logic        rsp_irq_ff, rsp_irq_in;
   logic [7:0]  station_ff [0:5][0:5];

   logic        load_ok, accept, is_write, ram_sel, ram_rd, ram_wr, station_wr;
   logic [3:0]  win_code;
   logic [15:0] a1_rd, a2_rd, a1_wr, a2_wr, rd_imm;
   logic [7:0]  ram_rd_lo, ram_rd_hi;
   ram_req_type ram_req;

   assign load_ok   = !rsp_valid_ff || !rsp_stall;
   // Interlock: hold off new transactions while a RAM access is still in progress or the result register cannot load
   assign req_stall = (phase_ff != PH_IDLE) || !load_ok;
   assign accept    = req_valid && !req_stall;
   assign is_write  = (req_kind == KIND_WRITE);
   assign win_code  = cfg1_ff[3:0];
   assign ram_sel   = (req_reg_index == REG_WINDOW) && (win_code == WIN_RAM);
   assign ram_rd    = accept && !is_write && ram_sel;
   assign ram_wr    = accept && is_write && ram_sel;
   assign station_wr = accept && is_write && (req_reg_index == REG_WINDOW)
                       && (win_code inside {[4'd0:WIN_STATION_LAST]});

   assign a1_rd = adv_read(dma_ff, tx_end_ff);
   assign a2_rd = adv_read(a1_rd, tx_end_ff);
   assign a1_wr = adv_write(dma_ff, tx_end_ff);
   assign a2_wr = adv_write(a1_wr, tx_end_ff);

   always_comb begin
      ram_req.wr_en    = ram_wr || (phase_ff == PH_WR);
      ram_req.wr_addr  = (phase_ff == PH_WR) ? wr_addr_ff : dma_ff;
      ram_req.wr_data  = (phase_ff == PH_WR) ? wr_byte_ff : req_write_data[7:0];
      ram_req.rd_en    = ram_rd;
      ram_req.rd_addr0 = dma_ff;
      ram_req.rd_addr1 = a1_rd;
   end

   echr_buffer_ram u_buffer_ram (
      .clock    (clock),
      .ram_req  (ram_req),
      .rd_data0 (ram_rd_lo),
      .rd_data1 (ram_rd_hi)
   );

   always_comb begin
      case (req_reg_index)
         REG_CMD:    rd_imm = status_ff;
         REG_CFG1:   rd_imm = cfg1_ff;
         REG_CFG2:   rd_imm = cfg2_ff;
         REG_RX_END: rd_imm = {8'h00, rx_end_ff[15:8]};
         REG_WINDOW: rd_imm = NO_DATA;
         REG_RX_PTR: rd_imm = rx_ptr_ff;
         REG_TX_PTR: rd_imm = tx_ptr_ff;
         REG_DMA:    rd_imm = dma_ff;
         default:    rd_imm = 16'd0;
      endcase
   end

   always_comb begin
      command_in   = command_ff;
      status_in    = status_ff;
      cfg1_in      = cfg1_ff;
      cfg2_in      = cfg2_ff;
      rx_end_in    = rx_end_ff;
      tx_end_in    = tx_end_ff;
      rx_ptr_in    = rx_ptr_ff;
      tx_ptr_in    = tx_ptr_ff;
      dma_in       = dma_ff;
      phase_in     = phase_ff;
      wr_addr_in   = wr_addr_ff;
      wr_byte_in   = wr_byte_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_irq_in   = rsp_irq_ff;

      case (phase_ff)
         PH_WR:   phase_in = PH_IDLE;
         PH_RD:   if (load_ok) phase_in = PH_IDLE;
         default: phase_in = phase_ff;
      endcase

      if (accept && is_write) begin
         case (req_reg_index)
            REG_CMD: begin
               command_in = req_write_data;
               status_in  = cmd_status(status_ff, req_write_data);
            end
            REG_CFG1:   cfg1_in   = req_write_data;
            REG_CFG2:   cfg2_in   = req_write_data;
            REG_RX_END: rx_end_in = {req_write_data[7:0], 8'h00};
            REG_WINDOW: begin
               if (win_code == WIN_TX_END) begin
                  tx_end_in = {req_write_data[7:0], 8'h00};
               end else if (win_code == WIN_RAM) begin
                  // low byte goes out now, high byte in the next cycle
                  dma_in     = a2_wr;
                  wr_addr_in = a1_wr;
                  wr_byte_in = req_write_data[15:8];
                  phase_in   = PH_WR;
               end
            end
            REG_RX_PTR: rx_ptr_in = req_write_data;
            REG_TX_PTR: tx_ptr_in = req_write_data;
            REG_DMA:    dma_in    = req_write_data;
            default:    dma_in    = dma_ff;
         endcase
      end

      if (ram_rd) begin
         dma_in   = a2_rd;
         phase_in = PH_RD;
      end

      if (accept && !ram_rd) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = is_write ? 16'd0 : rd_imm;
         rsp_irq_in   = |(status_in[7:4] & command_in[3:0]);
      end else if ((phase_ff == PH_RD) && load_ok) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {ram_rd_hi, ram_rd_lo};
         rsp_irq_in   = |(status_ff[7:4] & command_ff[3:0]);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         command_ff   <= '0;
         status_ff    <= '0;
         cfg1_ff      <= '0;
         cfg2_ff      <= '0;
         rx_end_ff    <= '0;
         tx_end_ff    <= '0;
         rx_ptr_ff    <= '0;
         tx_ptr_ff    <= '0;
         dma_ff       <= '0;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         command_ff   <= command_in;
         status_ff    <= status_in;
         cfg1_ff      <= cfg1_in;
         cfg2_ff      <= cfg2_in;
         rx_end_ff    <= rx_end_in;
         tx_end_ff    <= tx_end_in;
         rx_ptr_ff    <= rx_ptr_in;
         tx_ptr_ff    <= tx_ptr_in;
         dma_ff       <= dma_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff  <= wr_addr_in;
      wr_byte_ff  <= wr_byte_in;
      rsp_data_ff <= rsp_data_in;
      rsp_irq_ff  <= rsp_irq_in;
   end

   // Shift the new byte into the selected station address slot
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < 6; s++) begin
            for (int b = 0; b < 6; b++) begin
               station_ff[s][b] <= 8'h00;
            end
         end
      end else if (station_wr) begin
         for (int s = 0; s < 6; s++) begin
            if (win_code[2:0] == 3'(s)) begin
               for (int b = 0; b < 5; b++) begin
                  station_ff[s][b] <= station_ff[s][b+1];
               end
               station_ff[s][5] <= req_write_data[7:0];
            end
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_irq       = rsp_irq_ff;

endmodule

>>> hw/rtl/echr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// echr_checker
// Port-level checks for the host register block, bound to the top level.
// ----------------------------------------------------------------------------
module echr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_kind,
   input logic [2:0]  req_reg_index,
   input logic [15:0] req_write_data,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_read_data,
   input logic        rsp_irq
);
   import echr_pkg::*;

   logic req_fire;
   assign req_fire = req_valid && !req_stall;

   // No result survives a reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_irq))
      else $error("stalled result changed");

   // A write transaction answers with zero in the next cycle
   a_write_zero: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_kind == KIND_WRITE) |=> rsp_valid && (rsp_read_data == 16'd0))
      else $error("write transaction did not return zero");

   // Receive end area reads back as its high byte only
   a_rx_end_read: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_kind == KIND_READ) && (req_reg_index == REG_RX_END)
      |=> rsp_valid && (rsp_read_data[15:8] == 8'h00))
      else $error("receive end area read has high bits set");

endmodule

bind ethernet_controller_host_registers_unit echr_checker u_echr_checker (.*);

>>> verif/ethernet_controller_host_registers_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ethernet_controller_host_registers_unit_tb
// Drives host register reads and writes into the Ethernet host register
// block. A local copy of the register file, station slots and buffer RAM
// predicts every response. Responses are checked in order with random idling
// on both channels and one long hold-off on the response side.
// ----------------------------------------------------------------------------
module ethernet_controller_host_registers_unit_tb;
   import echr_pkg::*;

   localparam int ITEM_TARGET  = 900;
   localparam int TAIL_ITEMS   = 120;
   localparam int HOLD_AFTER   = 250;
   localparam int HOLD_CYCLES  = 300;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 10;
   localparam int MAX_REPORTS  = 10;
   localparam int SLOT_BYTES   = 6;

   localparam logic [3:0] WIN_STATION_FIRST = 4'd0;
   localparam logic [3:0] WIN_SPARE         = 4'd6;
   localparam logic [3:0] WIN_CODE_TOP      = 4'hf;

   localparam logic [15:0] CMD_ENABLE_MASK = 16'h000f;
   localparam logic [15:0] CMD_ACK_MASK    = 16'h00f0;
   localparam logic [15:0] CMD_DMA_ON      = 16'h0100;
   localparam logic [15:0] CMD_RX_ON       = 16'h0200;
   localparam logic [15:0] CMD_TX_ON       = 16'h0400;
   localparam logic [15:0] CMD_DMA_OFF     = 16'h0800;
   localparam logic [15:0] CMD_RX_OFF      = 16'h1000;
   localparam logic [15:0] CMD_TX_OFF      = 16'h2000;
   localparam logic [15:0] CMD_FIFO_READ   = 16'h4000;
   localparam logic [15:0] CMD_FIFO_WRITE  = 16'h8000;

   localparam logic [15:0] ST_DMA_IRQ   = 16'h0010;
   localparam logic [15:0] ST_RX_IRQ    = 16'h0020;
   localparam logic [15:0] ST_TX_IRQ    = 16'h0040;
   localparam logic [15:0] ST_DMA_ON    = 16'h0100;
   localparam logic [15:0] ST_RX_ON     = 16'h0200;
   localparam logic [15:0] ST_TX_ON     = 16'h0400;
   localparam logic [15:0] ST_FIFO_FULL = 16'h2000;
   localparam logic [15:0] ST_FIFO_EMPTY = 16'h4000;
   localparam logic [15:0] ST_FIFO_DIR  = 16'h8000;

   typedef struct packed {
      logic        kind;
      logic [2:0]  idx;
      logic [15:0] data;
   } access_type;

   typedef struct packed {
      logic [15:0] read_data;
      logic        irq;
   } reply_type;

   logic        clock;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic        req_kind       = KIND_READ;
   logic [2:0]  req_reg_index  = REG_CMD;
   logic [15:0] req_write_data = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [15:0] rsp_read_data;
   logic        rsp_irq;

   ethernet_controller_host_registers_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_irq        (rsp_irq)
   );

   access_type access_queue[$];
   reply_type  pending_replies[$];

   // Register file image for response prediction
   logic [15:0] cmd_reg    = '0;
   logic [15:0] status_reg = '0;
   logic [15:0] cfg_one    = '0;
   logic [15:0] cfg_two    = '0;
   logic [15:0] rx_end_reg = '0;
   logic [15:0] tx_end_reg = '0;
   logic [15:0] rx_ptr_reg = '0;
   logic [15:0] tx_ptr_reg = '0;
   logic [15:0] dma_reg    = '0;
   logic [7:0]  station_mem [0:35];
   logic [7:0]  ram_image [0:65535];

   // Stimulus-side tracking so that no unwritten RAM byte is ever read
   logic [3:0]  gen_code   = '0;
   logic [15:0] gen_tx_end = '0;
   logic [15:0] gen_dma    = '0;
   bit          gen_written [0:65535];

   int         total_items;
   int         reqs_accepted = 0;
   int         replies_seen  = 0;
   int         faults        = 0;
   int         idle_cycles   = 0;
   int         gap_left      = 0;
   int         stall_left    = 0;
   int         hold_left     = 0;
   bit         hold_done     = 0;
   bit         calm          = 0;
   access_type next_access;
   access_type seen_access;
   reply_type  want;
   reply_type  got;

   function automatic logic [15:0] dma_after_read(logic [15:0] addr, logic [15:0] tx_end);
      logic [15:0] n;
      n = addr + 16'd1;
      if (n == 16'h0000) n = tx_end + END_OFFSET;
      return n;
   endfunction

   function automatic logic [15:0] dma_after_write(logic [15:0] addr, logic [15:0] tx_end);
      logic [15:0] n;
      n = addr + 16'd1;
      if (n == tx_end + END_OFFSET) n = 16'h0000;
      return n;
   endfunction

   // On and off together raise the unit's interrupt and leave its on bit alone
   function automatic logic [15:0] unit_switch(logic [15:0] st, logic [15:0] c,
                                               logic [15:0] on_bit, logic [15:0] off_bit,
                                               logic [15:0] irq_bit, logic [15:0] state_bit);
      if ((c & on_bit) != 0 && (c & off_bit) != 0) return st | irq_bit;
      if ((c & on_bit) != 0) return st | state_bit;
      if ((c & off_bit) != 0) return st & ~state_bit;
      return st;
   endfunction

   function automatic reply_type predict_access(access_type a);
      reply_type  r;
      logic [3:0] code;
      int         base;
      r.read_data = 16'h0000;
      code = cfg_one[3:0];
      if (a.kind == KIND_WRITE) begin
         case (a.idx)
            REG_CMD: begin
               cmd_reg = a.data;
               status_reg = (status_reg & ~CMD_ENABLE_MASK) | (a.data & CMD_ENABLE_MASK);
               status_reg = status_reg & ~(a.data & CMD_ACK_MASK);
               status_reg = unit_switch(status_reg, a.data, CMD_DMA_ON, CMD_DMA_OFF,
                                        ST_DMA_IRQ, ST_DMA_ON);
               status_reg = unit_switch(status_reg, a.data, CMD_RX_ON, CMD_RX_OFF,
                                        ST_RX_IRQ, ST_RX_ON);
               status_reg = unit_switch(status_reg, a.data, CMD_TX_ON, CMD_TX_OFF,
                                        ST_TX_IRQ, ST_TX_ON);
               // FIFO write is applied after FIFO read, so it wins
               if ((a.data & CMD_FIFO_READ) != 0)
                  status_reg = (status_reg | ST_FIFO_DIR | ST_FIFO_FULL) & ~ST_FIFO_EMPTY;
               if ((a.data & CMD_FIFO_WRITE) != 0)
                  status_reg = (status_reg & ~(ST_FIFO_DIR | ST_FIFO_FULL)) | ST_FIFO_EMPTY;
            end
            REG_CFG1:   cfg_one = a.data;
            REG_CFG2:   cfg_two = a.data;
            REG_RX_END: rx_end_reg = {a.data[7:0], 8'h00};
            REG_WINDOW: begin
               if (code <= WIN_STATION_LAST) begin
                  base = int'(code) * SLOT_BYTES;
                  for (int i = 0; i < SLOT_BYTES - 1; i++)
                     station_mem[base + i] = station_mem[base + i + 1];
                  station_mem[base + SLOT_BYTES - 1] = a.data[7:0];
               end else if (code == WIN_TX_END) begin
                  tx_end_reg = {a.data[7:0], 8'h00};
               end else if (code == WIN_RAM) begin
                  ram_image[dma_reg] = a.data[7:0];
                  dma_reg = dma_after_write(dma_reg, tx_end_reg);
                  ram_image[dma_reg] = a.data[15:8];
                  dma_reg = dma_after_write(dma_reg, tx_end_reg);
               end
            end
            REG_RX_PTR: rx_ptr_reg = a.data;
            REG_TX_PTR: tx_ptr_reg = a.data;
            default:    dma_reg = a.data;
         endcase
      end else begin
         case (a.idx)
            REG_CMD:    r.read_data = status_reg;
            REG_CFG1:   r.read_data = cfg_one;
            REG_CFG2:   r.read_data = cfg_two;
            REG_RX_END: r.read_data = {8'h00, rx_end_reg[15:8]};
            REG_WINDOW: begin
               if (code != WIN_RAM) begin
                  r.read_data = NO_DATA;
               end else begin
                  r.read_data[7:0] = ram_image[dma_reg];
                  dma_reg = dma_after_read(dma_reg, tx_end_reg);
                  r.read_data[15:8] = ram_image[dma_reg];
                  dma_reg = dma_after_read(dma_reg, tx_end_reg);
               end
            end
            REG_RX_PTR: r.read_data = rx_ptr_reg;
            REG_TX_PTR: r.read_data = tx_ptr_reg;
            default:    r.read_data = dma_reg;
         endcase
      end
      r.irq = |(status_reg[7:4] & cmd_reg[3:0]);
      return r;
   endfunction

   // Queue one access; a RAM read that would touch an unwritten byte
   // becomes a status read instead
   task automatic add_access(input logic k, input logic [2:0] idx, input logic [15:0] d);
      access_type a;
      a.kind = k;
      a.idx  = idx;
      a.data = d;
      if (k == KIND_READ && idx == REG_WINDOW && gen_code == WIN_RAM &&
          !(gen_written[gen_dma] && gen_written[dma_after_read(gen_dma, gen_tx_end)]))
         a.idx = REG_CMD;
      if (a.kind == KIND_WRITE) begin
         case (a.idx)
            REG_CFG1: gen_code = a.data[3:0];
            REG_DMA:  gen_dma = a.data;
            REG_WINDOW: begin
               if (gen_code == WIN_TX_END) begin
                  gen_tx_end = {a.data[7:0], 8'h00};
               end else if (gen_code == WIN_RAM) begin
                  gen_written[gen_dma] = 1'b1;
                  gen_dma = dma_after_write(gen_dma, gen_tx_end);
                  gen_written[gen_dma] = 1'b1;
                  gen_dma = dma_after_write(gen_dma, gen_tx_end);
               end
            end
            default: ;
         endcase
      end else if (a.idx == REG_WINDOW && gen_code == WIN_RAM) begin
         gen_dma = dma_after_read(dma_after_read(gen_dma, gen_tx_end), gen_tx_end);
      end
      access_queue.push_back(a);
   endtask

   task automatic build_stimulus();
      logic [15:0] rnd;
      logic [15:0] base;
      logic [2:0]  idx;
      int          words;
      // Command corners: enables, on/off together, acks, FIFO both ways
      add_access(KIND_READ,  REG_CMD, 16'hffff);
      add_access(KIND_WRITE, REG_CMD, CMD_ENABLE_MASK);
      add_access(KIND_WRITE, REG_CMD, CMD_DMA_ON | CMD_DMA_OFF | CMD_ENABLE_MASK);
      add_access(KIND_READ,  REG_CMD, 16'h0000);
      add_access(KIND_WRITE, REG_CMD, CMD_RX_ON | CMD_RX_OFF | CMD_TX_ON | ST_DMA_IRQ |
                                      CMD_ENABLE_MASK);
      add_access(KIND_WRITE, REG_CMD, CMD_FIFO_READ);
      add_access(KIND_WRITE, REG_CMD, CMD_FIFO_READ | CMD_FIFO_WRITE | CMD_ACK_MASK);
      add_access(KIND_WRITE, REG_CMD, 16'hffff);
      add_access(KIND_READ,  REG_CMD, 16'h0000);
      add_access(KIND_WRITE, REG_CMD, CMD_DMA_OFF | CMD_RX_OFF | CMD_TX_OFF);
      add_access(KIND_WRITE, REG_RX_END, 16'habcd);
      add_access(KIND_READ,  REG_RX_END, 16'h0000);
      add_access(KIND_WRITE, REG_CFG2, 16'hffff);
      // Transmit end at the top so the wrap limit lands on zero
      add_access(KIND_WRITE, REG_CFG1, {12'hfff, WIN_TX_END});
      add_access(KIND_WRITE, REG_WINDOW, 16'h12ff);
      add_access(KIND_WRITE, REG_CFG1, {12'h000, WIN_STATION_FIRST});
      add_access(KIND_WRITE, REG_WINDOW, 16'hffaa);
      add_access(KIND_WRITE, REG_CFG1, {12'h000, WIN_SPARE});
      add_access(KIND_WRITE, REG_WINDOW, 16'hffff);
      add_access(KIND_WRITE, REG_CFG1, {12'h000, WIN_CODE_TOP});
      add_access(KIND_READ,  REG_WINDOW, 16'h0000);
      // RAM words across the top of the address space, then read back
      add_access(KIND_WRITE, REG_CFG1, {12'h000, WIN_RAM});
      add_access(KIND_WRITE, REG_DMA, 16'hfffe);
      add_access(KIND_WRITE, REG_WINDOW, 16'hbeef);
      add_access(KIND_WRITE, REG_WINDOW, 16'h1234);
      add_access(KIND_WRITE, REG_DMA, 16'hfffe);
      add_access(KIND_READ,  REG_WINDOW, 16'h0000);
      add_access(KIND_READ,  REG_WINDOW, 16'h0000);
      add_access(KIND_READ,  REG_DMA, 16'h0000);

      while (access_queue.size() < ITEM_TARGET) begin
         rnd = 16'($urandom);
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               words = $urandom_range(1, 6);
               case ($urandom_range(0, 2))
                  0: base = 16'($urandom);
                  1: base = 16'h0000 - 16'($urandom_range(1, 8));
                  default: base = gen_tx_end + END_OFFSET - 16'($urandom_range(1, 8));
               endcase
               add_access(KIND_WRITE, REG_CFG1, {rnd[15:4], WIN_RAM});
               add_access(KIND_WRITE, REG_DMA, base);
               repeat (words) add_access(KIND_WRITE, REG_WINDOW, 16'($urandom));
               add_access(KIND_WRITE, REG_DMA, base);
               repeat ($urandom_range(1, words))
                  add_access(KIND_READ, REG_WINDOW, 16'($urandom));
               if ($urandom_range(0, 1) == 0) add_access(KIND_READ, REG_DMA, 16'($urandom));
            end
            4: begin
               add_access(KIND_WRITE, REG_CFG1, {rnd[15:4], WIN_TX_END});
               add_access(KIND_WRITE, REG_WINDOW, 16'($urandom));
            end
            5: begin
               add_access(KIND_WRITE, REG_CFG1, {rnd[15:4], 4'($urandom_range(0, 5))});
               repeat ($urandom_range(1, 8))
                  add_access(KIND_WRITE, REG_WINDOW, 16'($urandom));
            end
            6: begin
               // Thin out the bits now and then so single controls stand alone
               if ($urandom_range(0, 1) == 0) rnd = rnd & 16'($urandom) & 16'($urandom);
               add_access(KIND_WRITE, REG_CMD, rnd);
               if ($urandom_range(0, 1) == 0) add_access(KIND_READ, REG_CMD, 16'($urandom));
            end
            7: begin
               case ($urandom_range(0, 5))
                  0: idx = REG_CFG1;
                  1: idx = REG_CFG2;
                  2: idx = REG_RX_END;
                  3: idx = REG_RX_PTR;
                  4: idx = REG_TX_PTR;
                  default: idx = REG_DMA;
               endcase
               add_access(KIND_WRITE, idx, rnd);
               add_access(KIND_READ, idx, 16'($urandom));
            end
            default: add_access(1'($urandom), 3'($urandom), rnd);
         endcase
      end
   endtask

   task automatic note_fault(input string what);
      faults++;
      if (faults <= MAX_REPORTS)
         $display("%0t %s: expected read_data=%h irq=%b, got read_data=%h irq=%b",
                  $realtime, what, want.read_data, want.irq, got.read_data, got.irq);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  <= 0;
      end else if (!req_valid || !req_stall) begin
         calm <= (access_queue.size() < TAIL_ITEMS);
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left  <= gap_left - 1;
         end else if (access_queue.size() == 0) begin
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            req_valid <= 1'b0;
            gap_left  <= $urandom_range(0, 16);
         end else begin
            next_access = access_queue.pop_front();
            req_valid      <= 1'b1;
            req_kind       <= next_access.kind;
            req_reg_index  <= next_access.idx;
            req_write_data <= next_access.data;
         end
      end
   end

   // Response stall: random bursts plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && replies_seen >= HOLD_AFTER) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 16);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Monitor: check responses, predict accepted requests, watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got.read_data = rsp_read_data;
            got.irq       = rsp_irq;
            if (pending_replies.size() == 0) begin
               want = '0;
               note_fault("unexpected response");
            end else begin
               want = pending_replies.pop_front();
               if (want.read_data !== got.read_data || want.irq !== got.irq)
                  note_fault("response mismatch");
            end
            replies_seen <= replies_seen + 1;
         end
         if (req_valid && !req_stall) begin
            seen_access.kind = req_kind;
            seen_access.idx  = req_reg_index;
            seen_access.data = req_write_data;
            pending_replies.push_back(predict_access(seen_access));
            reqs_accepted <= reqs_accepted + 1;
         end
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
               $display("[ethernet_controller_host_registers_unit] ERROR");
               $finish;
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < 36; i++) station_mem[i] = 8'h00;
      build_stimulus();
      total_items = access_queue.size();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock);
      while (reqs_accepted != total_items || pending_replies.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (faults == 0 && pending_replies.size() == 0)
         $display("[ethernet_controller_host_registers_unit] OK");
      else
         $display("[ethernet_controller_host_registers_unit] ERROR");
      $finish;
   end

endmodule

>>> ethernet_controller_host_registers_unit.f
hw/rtl/echr_pkg.sv
hw/rtl/echr_buffer_ram.sv
hw/rtl/ethernet_controller_host_registers_unit.sv
hw/rtl/echr_checker.sv
verif/ethernet_controller_host_registers_unit_tb.sv
